/* hw/rtl/quadratic_probe_hash_table_assert.svh */
// assertion macros for the quadratic probe hash table
`ifndef QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH
// property that must hold when not in reset
`define QPHT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// implication that must hold when not in reset
`define QPHT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`endif

/* hw/rtl/qpht_pkg.sv */
// shared types and codes for the quadratic probe hash table
`default_nettype none
package qpht_pkg;
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] POL_PRESENT = 2'd1;
   localparam logic [1:0] POL_ABSENT  = 2'd2;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_REPLACED = 3'd1;
   localparam logic [2:0] ST_SKIPPED  = 3'd2;
   localparam logic [2:0] ST_REMOVED  = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_FOUND    = 3'd5;
   localparam logic [2:0] ST_FULL     = 3'd6;
   localparam logic [2:0] ST_CLEARED  = 3'd7;

   localparam logic [1:0] ROW_EMPTY  = 2'd0;
   localparam logic [1:0] ROW_ACTIVE = 2'd1;
   localparam logic [1:0] ROW_TOMB   = 2'd2;

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_MOD, S_READ, S_CHECK, S_OUT
   } state_type;
endpackage
`default_nettype wire

/* hw/rtl/qpht_front.sv */
// request front end: two-entry word queue that decouples intake from the probe engine
`default_nettype none
`include "quadratic_probe_hash_table_assert.svh"
module qpht_front #(
   parameter int HASH_BITS  = 32,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_operation,
   input  wire logic [1:0]            req_insert_policy,
   input  wire logic [HASH_BITS-1:0]  req_hash,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       q_valid,
   input  wire logic                  q_take,
   output logic [1:0]                 q_operation,
   output logic                       q_is_insert_new,
   output logic [1:0]                 q_insert_policy,
   output logic [HASH_BITS-1:0]       q_hash,
   output logic [KEY_BITS-1:0]        q_key,
   output logic [VALUE_BITS-1:0]      q_value
);
   localparam int W = 2 + 2 + HASH_BITS + KEY_BITS + VALUE_BITS;
   logic [W-1:0] mem_ff [2];
   logic [1:0]   cnt_ff, cnt_in;
   logic         rd_ff, rd_in, wr_ff, wr_in;
   logic         push, pop;
   logic [W-1:0] head;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign pop  = q_take && q_valid;
   assign q_valid = (cnt_ff != 2'd0);
   assign head = mem_ff[rd_ff];
   assign {q_operation, q_insert_policy, q_hash, q_key, q_value} = head;
   // classify: insert that may create a new row (still checked against probe result)
   assign q_is_insert_new = (q_operation == qpht_pkg::OP_INSERT)
                            && (q_insert_policy != qpht_pkg::POL_PRESENT);

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= {req_operation, req_insert_policy, req_hash, req_key, req_value};
      end
   end

   `QPHT_ASSERT(a_cnt_range, cnt_ff != 2'd3, "queue count out of range")
   `QPHT_IMPLY(a_no_overflow, cnt_ff == 2'd2 && !pop, $past(1'b1) && cnt_in == 2'd2,
      "queue overflow")
   `QPHT_IMPLY(a_ptr_sync, cnt_ff == 2'd0, rd_ff == wr_ff, "empty queue pointers differ")
endmodule
`default_nettype wire

/* hw/rtl/qpht_back.sv */
// probe engine: row memories, modulo unit, probe sequencer and result register
`default_nettype none
`include "quadratic_probe_hash_table_assert.svh"
module qpht_back #(
   parameter int ROWS       = 1021,
   parameter int HASH_BITS  = 32,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [9:0]            csr_data,
   input  wire logic                  q_valid,
   output logic                       q_take,
   input  wire logic [1:0]            q_operation,
   input  wire logic                  q_is_insert_new,
   input  wire logic [1:0]            q_insert_policy,
   input  wire logic [HASH_BITS-1:0]  q_hash,
   input  wire logic [KEY_BITS-1:0]   q_key,
   input  wire logic [VALUE_BITS-1:0] q_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic                       rsp_found,
   output logic [VALUE_BITS-1:0]      rsp_value_out,
   output logic [9:0]                 rsp_entry_count
);
   localparam int RB = $clog2(ROWS);
   localparam int CB = RB + 1;
   localparam logic [CB-1:0] ROWS_C = CB'(ROWS);
   localparam int FW = (HASH_BITS > RB) ? HASH_BITS : RB + 1;
   localparam logic [FW-1:0] FOLD_C   = FW'((1 << RB) % ROWS);
   localparam logic [FW-1:0] LOW_MASK = FW'((1 << RB) - 1);
   localparam logic [FW-1:0] ROWS_F   = FW'(ROWS);

   logic [KEY_BITS-1:0]   key_mem   [ROWS];
   logic [VALUE_BITS-1:0] val_mem   [ROWS];
   logic [HASH_BITS-1:0]  hash_mem  [ROWS];
   logic [1:0]            stat_mem  [ROWS];

   qpht_pkg::state_type state_ff, state_in;
   logic [9:0]            max_ff, cnt_ff, cnt_in;
   logic [RB-1:0]         x_ff, x_in;
   logic [CB-1:0]         step_ff, step_in;   // probe increment, grows by two each probe, kept below ROWS
   logic [CB-1:0]         i_ff, i_in;
   logic [FW-1:0]         rem_ff, rem_in;     // hash being folded into the row range
   logic [FW-1:0]         rem_hi, rem_fold, rem_red;
   logic [1:0]            op_ff;
   logic                  new_ff;
   logic [1:0]            pol_ff;
   logic [HASH_BITS-1:0]  h_ff;
   logic [KEY_BITS-1:0]   k_ff, rk;
   logic [VALUE_BITS-1:0] v_ff, rv;
   logic [HASH_BITS-1:0]  rh;
   logic [1:0]            rs;
   logic                  out_v_ff, out_v_in;
   logic [2:0]            o_st_ff, o_st_in;
   logic                  o_f_ff, o_f_in;
   logic [VALUE_BITS-1:0] o_v_ff, o_v_in;
   logic                  we, we_stat;
   logic [1:0]            wstat;
   logic [RB-1:0]         waddr;
   logic [CB:0]           xsum;
   logic [CB-1:0]         stepw, xn;
   logic                  hit;

   assign csr_ready = 1'b1;
   assign rsp_valid = out_v_ff;
   assign rsp_status = o_st_ff;
   assign rsp_found = o_f_ff;
   assign rsp_value_out = o_v_ff;
   assign rsp_entry_count = cnt_ff;
   assign hit = (rs == qpht_pkg::ROW_ACTIVE) && (rh == h_ff) && (rk == k_ff);
   // 2^RB is FOLD_C modulo ROWS, so the bits above the row width fold back in
   assign rem_hi = rem_ff >> RB;
   assign rem_fold = FW'(rem_hi * FOLD_C) + (rem_ff & LOW_MASK);
   assign rem_red = (rem_ff >= ROWS_F) ? rem_ff - ROWS_F : rem_ff;
   assign xsum = {1'b0, CB'(x_ff)} + {1'b0, step_ff};
   assign stepw = (xsum >= {1'b0, ROWS_C}) ? CB'(xsum - {1'b0, ROWS_C}) : CB'(xsum);
   assign xn = (stepw >= ROWS_C) ? stepw - ROWS_C : stepw;

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; step_in = step_ff; i_in = i_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      out_v_in = out_v_ff && rsp_stall;
      o_st_in = o_st_ff; o_f_in = o_f_ff; o_v_in = o_v_ff;
      q_take = 1'b0;
      we = 1'b0; we_stat = 1'b0; wstat = qpht_pkg::ROW_EMPTY; waddr = x_ff;
      unique case (state_ff)
         qpht_pkg::S_INIT: begin
            // clearing sweep over row status
            we_stat = 1'b1;
            if (x_ff == RB'(ROWS - 1)) begin
               if (op_ff == qpht_pkg::OP_CLEAR && !out_v_in) begin
                  x_in = '0;
                  out_v_in = 1'b1; o_st_in = qpht_pkg::ST_CLEARED;
                  o_f_in = 1'b0; o_v_in = '0; cnt_in = '0;
                  state_in = qpht_pkg::S_IDLE;
               end else if (op_ff != qpht_pkg::OP_CLEAR) begin
                  x_in = '0;
                  state_in = qpht_pkg::S_IDLE;
               end
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         qpht_pkg::S_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               x_in = '0;
               if (q_operation == qpht_pkg::OP_CLEAR) begin
                  state_in = qpht_pkg::S_INIT;
               end else begin
                  rem_in = FW'(q_hash);
                  state_in = qpht_pkg::S_MOD;
               end
            end
         end
         qpht_pkg::S_MOD: begin
            // one fold per cycle until the value fits the row width
            if (rem_hi == '0) begin
               x_in = RB'(rem_red);
               step_in = CB'(1); i_in = '0;
               state_in = qpht_pkg::S_READ;
            end else begin
               rem_in = rem_fold;
            end
         end
         qpht_pkg::S_READ: state_in = qpht_pkg::S_CHECK;
         qpht_pkg::S_CHECK: begin
            if (rs == qpht_pkg::ROW_EMPTY || hit || i_ff == ROWS_C - 1'b1) begin
               state_in = qpht_pkg::S_OUT;
            end else begin
               x_in = RB'(xn);
               step_in = (step_ff + CB'(2) >= ROWS_C << 0) && (step_ff + CB'(2) >= ROWS_C)
                         ? step_ff + CB'(2) - ROWS_C : step_ff + CB'(2);
               i_in = i_ff + 1'b1;
               state_in = qpht_pkg::S_READ;
            end
         end
         qpht_pkg::S_OUT: begin
            if (!out_v_in) begin
               out_v_in = 1'b1; o_f_in = hit; o_v_in = '0;
               state_in = qpht_pkg::S_IDLE;
               case (op_ff)
                  qpht_pkg::OP_LOOKUP: begin
                     o_st_in = hit ? qpht_pkg::ST_FOUND : qpht_pkg::ST_NOTFOUND;
                     if (hit) o_v_in = rv;
                  end
                  qpht_pkg::OP_REMOVE: begin
                     if (hit) begin
                        o_st_in = qpht_pkg::ST_REMOVED;
                        we_stat = 1'b1; wstat = qpht_pkg::ROW_TOMB;
                        if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
                     end else begin
                        o_st_in = qpht_pkg::ST_NOTFOUND;
                     end
                  end
                  default: begin
                     if (hit && pol_ff == qpht_pkg::POL_ABSENT) begin
                        o_st_in = qpht_pkg::ST_SKIPPED;
                     end else if (!hit && !new_ff) begin
                        o_st_in = qpht_pkg::ST_SKIPPED;
                     end else if (hit) begin
                        o_st_in = qpht_pkg::ST_REPLACED; we = 1'b1;
                     end else if (rs != qpht_pkg::ROW_EMPTY || cnt_ff >= max_ff) begin
                        o_st_in = qpht_pkg::ST_FULL;
                     end else begin
                        o_st_in = qpht_pkg::ST_INSERTED; we = 1'b1;
                        we_stat = 1'b1; wstat = qpht_pkg::ROW_ACTIVE;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         default: state_in = qpht_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qpht_pkg::S_INIT;
         x_ff <= '0;
         op_ff <= qpht_pkg::OP_LOOKUP;
         max_ff <= 10'd510;
         cnt_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         x_ff <= x_in;
         if (q_take) op_ff <= q_operation;
         if (csr_valid && csr_ready) max_ff <= csr_data;
         cnt_ff <= cnt_in;
         out_v_ff <= out_v_in;
      end
      step_ff <= step_in; i_ff <= i_in;
      rem_ff <= rem_in;
      o_st_ff <= o_st_in; o_f_ff <= o_f_in; o_v_ff <= o_v_in;
      if (q_take) begin
         new_ff <= q_is_insert_new; pol_ff <= q_insert_policy;
         h_ff <= q_hash; k_ff <= q_key; v_ff <= q_value;
      end
   end

   // row memories, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         key_mem[waddr] <= k_ff; val_mem[waddr] <= v_ff; hash_mem[waddr] <= h_ff;
      end
      if (we_stat) stat_mem[waddr] <= wstat;
      rk <= key_mem[x_ff]; rv <= val_mem[x_ff];
      rh <= hash_mem[x_ff]; rs <= stat_mem[x_ff];
   end

   `QPHT_IMPLY(a_take_idle, q_take, state_ff == qpht_pkg::S_IDLE, "take outside idle")
   `QPHT_ASSERT(a_row_range, x_ff <= RB'(ROWS - 1), "row index out of range")
   `QPHT_IMPLY(a_hold, rsp_valid && rsp_stall, ##1 rsp_valid && $stable(rsp_status),
      "stalled result changed")
endmodule
`default_nettype wire

/* hw/rtl/quadratic_probe_hash_table.sv */
// top level of the quadratic probe hash table
// Usage: requests enter on req_* (valid/stall). Each word carries operation,
// insert_policy, hash, key and value, and produces exactly one result word on
// rsp_* (valid/stall) with status, found, value_out and entry_count.
// csr_* (valid/ready) writes max_entries; write only while idle.
// The modulo unit folds the hash into the row range, one fold a cycle, then
// each probed row is read from memory and compared, and then the result is
// posted. Clear sweeps every row. Throughput is one request per probe
// sequence; the two-word request queue keeps accepting while the engine
// works, until it is full. After reset the row status memory is swept
// empty before the first request is taken. When the receiver stalls the
// result word is held and the engine waits before posting the next one.
`default_nettype none
module quadratic_probe_hash_table #(
   parameter int ROWS       = 1021,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   parameter int HASH_BITS  = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_operation,
   input  wire logic [1:0]            req_insert_policy,
   input  wire logic [HASH_BITS-1:0]  req_hash,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic                       rsp_found,
   output logic [VALUE_BITS-1:0]      rsp_value_out,
   output logic [9:0]                 rsp_entry_count,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [9:0]            csr_data
);
   logic                  q_valid, q_take, q_is_insert_new;
   logic [1:0]            q_operation, q_insert_policy;
   logic [HASH_BITS-1:0]  q_hash;
   logic [KEY_BITS-1:0]   q_key;
   logic [VALUE_BITS-1:0] q_value;

   qpht_front #(.HASH_BITS(HASH_BITS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS))
   u_front (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_insert_policy,
      .req_hash, .req_key, .req_value, .q_valid, .q_take, .q_operation,
      .q_is_insert_new, .q_insert_policy, .q_hash, .q_key, .q_value
   );

   qpht_back #(.ROWS(ROWS), .HASH_BITS(HASH_BITS), .KEY_BITS(KEY_BITS),
      .VALUE_BITS(VALUE_BITS))
   u_back (
      .clock, .reset, .csr_valid, .csr_ready, .csr_data, .q_valid, .q_take,
      .q_operation, .q_is_insert_new, .q_insert_policy, .q_hash, .q_key, .q_value,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_found, .rsp_value_out, .rsp_entry_count
   );
endmodule
`default_nettype wire
